// ===== rtl/pls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_pkg
// Shared constants and types of the piecewise-linear schedule block.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int NUM_POINTS_DEF = 6;
    localparam int STEP_BITS_DEF  = 24;
    localparam int FRAC_BITS_DEF  = 28;

    localparam int VALUE_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int USED_W    = 3;
    localparam int DIV_DIGIT = 4;

    localparam logic [CFG_IDX_W-1:0] REG_LAST_STEP   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS_USED = 3'd7;

    typedef enum logic [1:0] {
        OUT_NORMAL = 2'd0,
        OUT_SPAN   = 2'd1,
        OUT_SAT    = 2'd2
    } t_outcome;

    typedef struct packed {
        logic               hit;
        logic               degen;
        logic               neg;
        logic [VALUE_W-1:0] hit_val;
        logic [VALUE_W-1:0] start_val;
    } t_side;

endpackage

// ===== rtl/pls_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_scan
// One pipeline stage of the breakpoint scan over a fixed group of points.
// ----------------------------------------------------------------------------
module pls_scan #(
    parameter int NUM_POINTS = pls_pkg::NUM_POINTS_DEF,
    parameter int STEP_BITS  = pls_pkg::STEP_BITS_DEF,
    parameter int FIRST      = 0,
    parameter int COUNT      = 1
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_en,
    input  logic [NUM_POINTS-1:0][STEP_BITS+31:0]        i_points,
    input  logic [pls_pkg::USED_W-1:0]                   i_used,
    input  logic                                         i_valid,
    input  logic [STEP_BITS-1:0]                         i_q,
    input  logic [STEP_BITS-1:0]                         i_ss,
    input  logic [STEP_BITS-1:0]                         i_es,
    input  logic [31:0]                                  i_sv,
    input  logic [31:0]                                  i_ev,
    input  logic                                         i_hit,
    input  logic [31:0]                                  i_hv,
    output logic                                         o_valid,
    output logic [STEP_BITS-1:0]                         o_q,
    output logic [STEP_BITS-1:0]                         o_ss,
    output logic [STEP_BITS-1:0]                         o_es,
    output logic [31:0]                                  o_sv,
    output logic [31:0]                                  o_ev,
    output logic                                         o_hit,
    output logic [31:0]                                  o_hv
);
    import pls_pkg::*;

    logic                 r_valid;
    logic [STEP_BITS-1:0] r_q, r_ss, r_es;
    logic [31:0]          r_sv, r_ev, r_hv;
    logic                 r_hit;

    logic [STEP_BITS-1:0] n_ss, n_es;
    logic [31:0]          n_sv, n_ev, n_hv;
    logic                 n_hit;

    always_comb begin
        logic [STEP_BITS-1:0] ps;
        logic [31:0]          pv;
        n_ss  = i_ss;
        n_es  = i_es;
        n_sv  = i_sv;
        n_ev  = i_ev;
        n_hv  = i_hv;
        n_hit = i_hit;
        for (int k = 0; k < COUNT; k++) begin
            ps = i_points[FIRST+k][STEP_BITS-1:0];
            pv = i_points[FIRST+k][STEP_BITS+31:STEP_BITS];
            if (!n_hit && (USED_W'(FIRST+k) < i_used)) begin
                if (i_q == ps) begin
                    n_hit = 1'b1;
                    n_hv  = pv;
                end else if (i_q <= ps && ps <= n_es) begin
                    n_ev = pv;
                    n_es = ps;
                end else if (n_ss <= ps && ps <= i_q) begin
                    n_sv = pv;
                    n_ss = ps;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q   <= i_q;
            r_ss  <= n_ss;
            r_es  <= n_es;
            r_sv  <= n_sv;
            r_ev  <= n_ev;
            r_hv  <= n_hv;
            r_hit <= n_hit;
        end
    end

    assign o_valid = r_valid;
    assign o_q     = r_q;
    assign o_ss    = r_ss;
    assign o_es    = r_es;
    assign o_sv    = r_sv;
    assign o_ev    = r_ev;
    assign o_hit   = r_hit;
    assign o_hv    = r_hv;

endmodule

// ===== rtl/pls_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_div
// Pipelined restoring divider, a few quotient bits per stage, with side data.
// ----------------------------------------------------------------------------
module pls_div #(
    parameter int NUM_W  = 56,
    parameter int DEN_W  = 24,
    parameter int SIDE_W = 8,
    parameter int NSTG   = (NUM_W + pls_pkg::DIV_DIGIT - 1) / pls_pkg::DIV_DIGIT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [NUM_W-1:0]                 i_num,
    input  logic [DEN_W-1:0]                 i_den,
    input  logic [SIDE_W-1:0]                i_side,
    output logic                             o_valid,
    output logic [NSTG*pls_pkg::DIV_DIGIT-1:0] o_quot,
    output logic [SIDE_W-1:0]                o_side
);
    import pls_pkg::*;

    localparam int PAD_W = NSTG * DIV_DIGIT;

    logic              r_vld  [NSTG];
    logic [PAD_W-1:0]  r_acc  [NSTG];
    logic [DEN_W-1:0]  r_rem  [NSTG];
    logic [DEN_W-1:0]  r_den  [NSTG];
    logic [SIDE_W-1:0] r_side [NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic              in_vld;
        logic [PAD_W-1:0]  in_acc;
        logic [DEN_W-1:0]  in_rem;
        logic [DEN_W-1:0]  in_den;
        logic [SIDE_W-1:0] in_side;
        logic [PAD_W-1:0]  n_acc;
        logic [DEN_W-1:0]  n_rem;

        if (s == 0) begin : g_first
            assign in_vld  = i_valid;
            assign in_acc  = PAD_W'(i_num);
            assign in_rem  = '0;
            assign in_den  = i_den;
            assign in_side = i_side;
        end else begin : g_next
            assign in_vld  = r_vld[s-1];
            assign in_acc  = r_acc[s-1];
            assign in_rem  = r_rem[s-1];
            assign in_den  = r_den[s-1];
            assign in_side = r_side[s-1];
        end

        always_comb begin
            logic [DEN_W:0] t;
            n_acc = in_acc;
            n_rem = in_rem;
            for (int j = 0; j < DIV_DIGIT; j++) begin
                t     = {n_rem, n_acc[PAD_W-1]};
                n_acc = {n_acc[PAD_W-2:0], 1'b0};
                if (t >= {1'b0, in_den}) begin
                    t        = t - {1'b0, in_den};
                    n_acc[0] = 1'b1;
                end
                n_rem = t[DEN_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= in_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[s]  <= n_acc;
                r_rem[s]  <= n_rem;
                r_den[s]  <= in_den;
                r_side[s] <= in_side;
            end
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_quot  = r_acc[NSTG-1];
    assign o_side  = r_side[NSTG-1];

endmodule

// ===== rtl/piecewise_linear_schedule_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_schedule_top
// Evaluates a piecewise-linear schedule of up to NUM_POINTS breakpoints at a
// step, Q4.28 values, multiply then divide, saturating result.
//
//   channel   direction  handshake                 payload
//   query     in         i_valid / o_stall         i_query_step
//   result    out        o_valid / i_stall         o_sched_value, o_outcome
//   config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one query per cycle while the result is not stalled; the divider pipeline
// resolves four quotient bits per stage
// synchronous active-low reset clears valid bits, points and used count, sets last step to all ones
// a stalled result holds the whole pipeline; o_stall follows it
// ----------------------------------------------------------------------------
module piecewise_linear_schedule_top #(
    parameter int NUM_POINTS      = pls_pkg::NUM_POINTS_DEF,
    parameter int STEP_BITS       = pls_pkg::STEP_BITS_DEF,
    parameter int VALUE_FRAC_BITS = pls_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [STEP_BITS-1:0]             i_query_step,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [31:0]               o_sched_value,
    output logic [1:0]                       o_outcome,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pls_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [STEP_BITS+31:0]            i_cfg_data
);
    import pls_pkg::*;

    localparam int PT_W   = STEP_BITS + 32;
    localparam int PROD_W = 32 + STEP_BITS;
    localparam int NSTG   = (PROD_W + DIV_DIGIT - 1) / DIV_DIGIT;
    localparam int PAD_W  = NSTG * DIV_DIGIT;
    localparam int HALF   = (NUM_POINTS + 1) / 2;
    localparam int SIDE_W = $bits(t_side);
    localparam logic [31:0] DEFAULT_END =
        32'(((64'd1 << VALUE_FRAC_BITS) + 64'd5000) / 64'd10000);

    logic en;

    // configuration registers
    logic [NUM_POINTS-1:0][PT_W-1:0] r_point;
    logic [STEP_BITS-1:0]            r_last_step;
    logic [USED_W-1:0]               r_used;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point     <= '0;
            r_last_step <= '1;
            r_used      <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LAST_STEP:   r_last_step <= i_cfg_data[STEP_BITS-1:0];
                REG_POINTS_USED: r_used      <= i_cfg_data[USED_W-1:0];
                default: begin
                    for (int p = 0; p < NUM_POINTS; p++) begin
                        if (i_cfg_index == CFG_IDX_W'(p)) begin
                            r_point[p] <= i_cfg_data;
                        end
                    end
                end
            endcase
        end
    end

    // pipeline control
    logic r_out_valid;
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    // input register
    logic                 r0_valid;
    logic [STEP_BITS-1:0] r0_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (en) begin
            r0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_q <= i_query_step;
        end
    end

    // breakpoint scan, two stages
    logic                 a_valid, b_valid, a_hit, b_hit;
    logic [STEP_BITS-1:0] a_q, a_ss, a_es, b_q, b_ss, b_es;
    logic [31:0]          a_sv, a_ev, a_hv, b_sv, b_ev, b_hv;

    pls_scan #(
        .NUM_POINTS (NUM_POINTS),
        .STEP_BITS  (STEP_BITS),
        .FIRST      (0),
        .COUNT      (HALF)
    ) u_scan_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_points (r_point),
        .i_used   (r_used),
        .i_valid  (r0_valid),
        .i_q      (r0_q),
        .i_ss     ('0),
        .i_es     (r_last_step),
        .i_sv     (DEFAULT_END),
        .i_ev     (DEFAULT_END),
        .i_hit    (1'b0),
        .i_hv     (32'd0),
        .o_valid  (a_valid),
        .o_q      (a_q),
        .o_ss     (a_ss),
        .o_es     (a_es),
        .o_sv     (a_sv),
        .o_ev     (a_ev),
        .o_hit    (a_hit),
        .o_hv     (a_hv)
    );

    pls_scan #(
        .NUM_POINTS (NUM_POINTS),
        .STEP_BITS  (STEP_BITS),
        .FIRST      (HALF),
        .COUNT      (NUM_POINTS - HALF)
    ) u_scan_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_points (r_point),
        .i_used   (r_used),
        .i_valid  (a_valid),
        .i_q      (a_q),
        .i_ss     (a_ss),
        .i_es     (a_es),
        .i_sv     (a_sv),
        .i_ev     (a_ev),
        .i_hit    (a_hit),
        .i_hv     (a_hv),
        .o_valid  (b_valid),
        .o_q      (b_q),
        .o_ss     (b_ss),
        .o_es     (b_es),
        .o_sv     (b_sv),
        .o_ev     (b_ev),
        .o_hit    (b_hit),
        .o_hv     (b_hv)
    );

    // span, offset and value difference
    logic                 r3_valid;
    logic [31:0]          r3_mag;
    logic [STEP_BITS-1:0] r3_d, r3_span;
    t_side                r3_side;
    logic [32:0]          dv, dv_abs;

    assign dv     = {b_ev[31], b_ev} - {b_sv[31], b_sv};
    assign dv_abs = dv[32] ? (33'd0 - dv) : dv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_mag            <= dv_abs[31:0];
            r3_d              <= b_q - b_ss;
            r3_span           <= b_es - b_ss;
            r3_side.hit       <= b_hit;
            r3_side.degen     <= (b_es <= b_ss);
            r3_side.neg       <= dv[32];
            r3_side.hit_val   <= b_hv;
            r3_side.start_val <= b_sv;
        end
    end

    // product
    logic                 r4_valid;
    logic [PROD_W-1:0]    r4_prod;
    logic [STEP_BITS-1:0] r4_span;
    t_side                r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_prod <= PROD_W'(r3_mag) * PROD_W'(r3_d);
            r4_span <= r3_span;
            r4_side <= r3_side;
        end
    end

    // quotient
    logic             q_valid;
    logic [PAD_W-1:0] q_quot;
    t_side            q_side;

    pls_div #(
        .NUM_W  (PROD_W),
        .DEN_W  (STEP_BITS),
        .SIDE_W (SIDE_W),
        .NSTG   (NSTG)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_valid),
        .i_num   (r4_prod),
        .i_den   (r4_span),
        .i_side  (r4_side),
        .o_valid (q_valid),
        .o_quot  (q_quot),
        .o_side  (q_side)
    );

    // final sum and saturation; a hit or a degenerate span bypasses the sum
    logic        [33:0] qclip;
    logic signed [33:0] sum;
    logic        [31:0] n_value;
    t_outcome           n_outcome;

    always_comb begin
        qclip = (q_quot > PAD_W'(33'h1_0000_0000)) ? 34'h1_0000_0001 : 34'(q_quot[32:0]);
        sum   = $signed({{2{q_side.start_val[31]}}, q_side.start_val})
              + $signed(q_side.neg ? (34'd0 - qclip) : qclip);
        if (q_side.hit) begin
            n_value   = q_side.hit_val;
            n_outcome = OUT_NORMAL;
        end else if (q_side.degen) begin
            n_value   = q_side.start_val;
            n_outcome = OUT_SPAN;
        end else if (sum > 34'sh0_7FFF_FFFF) begin
            n_value   = 32'h7FFF_FFFF;
            n_outcome = OUT_SAT;
        end else if (sum < -34'sh0_8000_0000) begin
            n_value   = 32'h8000_0000;
            n_outcome = OUT_SAT;
        end else begin
            n_value   = sum[31:0];
            n_outcome = OUT_NORMAL;
        end
    end

    logic [31:0] r_out_value;
    t_outcome    r_out_outcome;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_value   <= n_value;
            r_out_outcome <= n_outcome;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_sched_value = r_out_value;
    assign o_outcome     = r_out_outcome;

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_outcome == OUT_SAT) |->
        (r_out_value == 32'h7FFF_FFFF || r_out_value == 32'h8000_0000))
        else $error("saturated result off the rails");

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_out_value)))
        else $error("stalled result lost");

    a_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_outcome != 2'd3))
        else $error("bad outcome code");

endmodule
